// File: rtl/cta_pkg.sv
package cta_pkg;

    // Table geometry.
    localparam int TABLE_DEPTH  = 8192;
    localparam int HEADER_BYTES = 8;
    localparam int IDX_W        = $clog2(TABLE_DEPTH);
    localparam int POS_W        = $clog2(TABLE_DEPTH + 1);

    // Line length register and its legal range.
    localparam int LEN_W          = 11;
    localparam int LINE_MAX_BYTES = 1024;
    localparam int LINE_RESET     = 64;
    localparam int OFF_W          = $clog2(LINE_MAX_BYTES);

    // Sample conversion: (v - 0x80) * 10 / 0x22, truncated toward zero.
    localparam logic [7:0] SAMPLE_BIAS = 8'h80;
    localparam int CONV_MUL   = 10;
    // Reciprocal of 0x22 scaled by 2^13; exact floor for products up to 1280.
    localparam int CONV_RECIP = 241;
    localparam int CONV_SHIFT = 13;

    // Queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // What the back part does with the table for one transaction.
    typedef enum logic [1:0] {
        OP_NONE,
        OP_STORE,
        OP_HOLD,
        OP_ADD
    } cta_op_t;

    typedef struct packed {
        cta_op_t          op;
        logic [IDX_W-1:0] index;
        logic [7:0]       value;
        logic [POS_W-1:0] table_length;
    } cta_entry_t;

    // Converted sample; its magnitude never exceeds 37, so no clipping is needed.
    function automatic logic [7:0] cta_convert(input logic [7:0] v);
        logic              neg;
        logic [7:0]        mag;
        logic [10:0]       prod;
        logic [18:0]       scaled;
        logic [5:0]        quo;
        neg    = (v < SAMPLE_BIAS);
        mag    = neg ? (SAMPLE_BIAS - v) : (v - SAMPLE_BIAS);
        prod   = 11'(mag) * 11'(CONV_MUL);
        scaled = 19'(prod) * 19'(CONV_RECIP);
        quo    = scaled[CONV_SHIFT +: 6];
        return neg ? (8'd0 - 8'(quo)) : 8'(quo);
    endfunction

    // Signed byte addition, saturating at -128 and 127.
    function automatic logic [7:0] cta_sat_add(input logic [7:0] a, input logic [7:0] b);
        logic signed [8:0] sum;
        sum = $signed({a[7], a}) + $signed({b[7], b});
        if (sum < -9'sd128)
        begin
            return 8'h80;
        end
        else if (sum > 9'sd127)
        begin
            return 8'h7f;
        end
        return sum[7:0];
    endfunction

endpackage

// File: rtl/cta_front.sv
module cta_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [cta_pkg::LEN_W-1:0]   cfg_wr_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        req_type,
    input  logic [7:0]                  sample,
    input  logic                        end_of_frame,
    input  logic                        q_ready,
    output logic                        q_push,
    output cta_pkg::cta_entry_t         q_entry
);
    import cta_pkg::*;

    logic [LEN_W-1:0] line_bytes_reg;
    logic [POS_W-1:0] stored_length_reg, stored_length_next;
    logic             table_valid_reg, table_valid_next;
    logic [POS_W-1:0] byte_position_reg, byte_position_next;
    logic [OFF_W-1:0] line_offset_reg, line_offset_next;

    logic [LEN_W-1:0] len_eff;
    logic [LEN_W-1:0] off_inc;
    logic             header;
    logic             in_range;
    logic [7:0]       conv;
    logic             accept;

    assign accept   = in_valid && q_ready;
    assign in_ready = q_ready;
    assign q_push   = accept;

    // Classify the byte and advance the frame position.
    always_comb
    begin
        if (line_bytes_reg == '0)
        begin
            len_eff = LEN_W'(1);
        end
        else if (line_bytes_reg > LEN_W'(LINE_MAX_BYTES))
        begin
            len_eff = LEN_W'(LINE_MAX_BYTES);
        end
        else
        begin
            len_eff = line_bytes_reg;
        end
        header   = (line_offset_reg < OFF_W'(HEADER_BYTES));
        in_range = (byte_position_reg < POS_W'(TABLE_DEPTH));
        conv     = cta_convert(sample);
        off_inc  = LEN_W'(line_offset_reg) + LEN_W'(1);

        stored_length_next = stored_length_reg;
        table_valid_next   = table_valid_reg;
        byte_position_next = byte_position_reg;
        line_offset_next   = line_offset_reg;

        q_entry.op    = OP_NONE;
        q_entry.index = byte_position_reg[IDX_W-1:0];
        q_entry.value = '0;

        if (!req_type)
        begin
            // Restart empties the table and rewinds the position.
            stored_length_next = '0;
            table_valid_next   = 1'b0;
            byte_position_next = '0;
            line_offset_next   = '0;
            q_entry.index      = '0;
        end
        else
        begin
            if (!table_valid_reg)
            begin
                if (in_range)
                begin
                    q_entry.op         = OP_STORE;
                    q_entry.value      = header ? sample : conv;
                    stored_length_next = byte_position_reg + POS_W'(1);
                end
            end
            else if (in_range && (byte_position_reg < stored_length_reg))
            begin
                q_entry.op    = header ? OP_HOLD : OP_ADD;
                q_entry.value = conv;
            end

            if (end_of_frame)
            begin
                if (!table_valid_reg && (stored_length_next != '0))
                begin
                    table_valid_next = 1'b1;
                end
                byte_position_next = '0;
                line_offset_next   = '0;
            end
            else
            begin
                if (in_range)
                begin
                    byte_position_next = byte_position_reg + POS_W'(1);
                end
                if (off_inc >= len_eff)
                begin
                    line_offset_next = '0;
                end
                else
                begin
                    line_offset_next = off_inc[OFF_W-1:0];
                end
            end
        end
        q_entry.table_length = stored_length_next;
    end

    // Frame state and the line length register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_bytes_reg    <= LEN_W'(LINE_RESET);
            stored_length_reg <= '0;
            table_valid_reg   <= 1'b0;
            byte_position_reg <= '0;
            line_offset_reg   <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                line_bytes_reg <= cfg_wr_data;
            end
            if (accept)
            begin
                stored_length_reg <= stored_length_next;
                table_valid_reg   <= table_valid_next;
                byte_position_reg <= byte_position_next;
                line_offset_reg   <= line_offset_next;
            end
        end
    end

endmodule

// File: rtl/cta_queue.sv
module cta_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  cta_pkg::cta_entry_t push_entry,
    output logic                push_ready,
    input  logic                pop,
    output logic                pop_valid,
    output cta_pkg::cta_entry_t pop_entry
);
    import cta_pkg::*;

    cta_entry_t        entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = entries_reg[rd_ptr_reg];

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                    : wr_ptr_reg + QPTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                    : rd_ptr_reg + QPTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Payload storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// File: rtl/cta_back.sv
module cta_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_valid,
    input  cta_pkg::cta_entry_t          q_entry,
    output logic                         q_pop,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [cta_pkg::IDX_W-1:0]    entry_index,
    output logic [7:0]                   entry_value,
    output logic                         written,
    output logic [cta_pkg::POS_W-1:0]    table_length
);
    import cta_pkg::*;

    logic [7:0]       table_mem [TABLE_DEPTH];
    logic [7:0]       rd_data_reg;

    logic             e_valid_reg;
    cta_entry_t       e_entry_reg;
    logic             e_fwd_reg;
    logic [7:0]       e_fwd_data_reg;

    logic             out_valid_reg;
    logic [IDX_W-1:0] out_index_reg;
    logic [7:0]       out_value_reg;
    logic             out_written_reg;
    logic [POS_W-1:0] out_length_reg;

    logic             e_adv;
    logic             e_wr;
    logic [7:0]       e_old;
    logic [7:0]       e_value;
    logic             fwd_hit;

    assign e_adv = e_valid_reg && (!out_valid_reg || out_ready);
    assign q_pop = q_valid && (!e_valid_reg || e_adv);

    // Update of the addressed entry; a write still in flight is forwarded.
    always_comb
    begin
        e_old = e_fwd_reg ? e_fwd_data_reg : rd_data_reg;
        e_wr  = 1'b0;
        unique case (e_entry_reg.op)
            OP_NONE:
            begin
                e_value = '0;
            end
            OP_STORE:
            begin
                e_value = e_entry_reg.value;
                e_wr    = 1'b1;
            end
            OP_HOLD:
            begin
                e_value = e_old;
            end
            OP_ADD:
            begin
                e_value = cta_sat_add(e_old, e_entry_reg.value);
                e_wr    = 1'b1;
            end
            default:
            begin
                e_value = '0;
            end
        endcase
        fwd_hit = e_adv && e_wr && (e_entry_reg.index == q_entry.index);
    end

    // Table memory: one read at dequeue, one write when the update retires.
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            rd_data_reg <= table_mem[q_entry.index];
        end
        if (e_adv && e_wr)
        begin
            table_mem[e_entry_reg.index] <= e_value;
        end
    end

    // Execute stage and output register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg   <= 1'b0;
            e_fwd_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                e_valid_reg <= 1'b1;
                e_fwd_reg   <= fwd_hit;
            end
            else if (e_adv)
            begin
                e_valid_reg <= 1'b0;
                e_fwd_reg   <= 1'b0;
            end
            if (e_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            e_entry_reg    <= q_entry;
            e_fwd_data_reg <= e_value;
        end
        if (e_adv)
        begin
            out_index_reg   <= e_entry_reg.index;
            out_value_reg   <= e_value;
            out_written_reg <= e_wr;
            out_length_reg  <= e_entry_reg.table_length;
        end
    end

    assign out_valid    = out_valid_reg;
    assign entry_index  = out_index_reg;
    assign entry_value  = out_value_reg;
    assign written      = out_written_reg;
    assign table_length = out_length_reg;

`ifndef SYNTHESIS
    // Dequeue only happens when the queue holds a transaction.
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
        else $error("dequeue from empty queue");

    // The forwarding flag only stands beside a transaction in the execute stage.
    assert property (@(posedge clk) disable iff (!rst_n) e_fwd_reg |-> e_valid_reg)
        else $error("forwarding flag without a transaction in the execute stage");

    // A retiring transaction always lands in the output register.
    assert property (@(posedge clk) disable iff (!rst_n) e_adv |=> out_valid_reg)
        else $error("retired transaction lost");

    // Forwarding follows a write that retired in the same cycle as the dequeue.
    assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && fwd_hit) |=> (e_fwd_reg && $past(e_wr)))
        else $error("forwarding without a matching write");
`endif

endmodule

// File: rtl/calibration_table_accumulator_unit.sv
// Calibration table accumulator.
// Input channel (in_valid/in_ready): one transaction per frame byte or restart.
// req_type 0 restarts calibration; req_type 1 carries a frame byte in sample,
// with end_of_frame on the last byte of a frame. Output channel
// (out_valid/out_ready): exactly one transaction per input transaction, in
// order, giving the addressed table index, the entry after the update, whether
// it was written, and the table length.
// Configuration: cfg_wr_en writes cfg_wr_data into the line length register
// in the same cycle; write it only while the block is idle.
// Throughput is one transaction per cycle while the receiver accepts outputs,
// set by the single table read-modify-write per byte on the 8192-entry memory.
// On acceptance the entry is written into the queue; at dequeue the table is
// read into the execute stage, and the update then lands in the output
// register, which drives out_valid.
// Reset clears the frame position, length and table-valid state and empties the
// queue and pipeline; table contents are undefined until the first frame
// writes them, and no clearing pass is run.
// When the receiver stalls, the output register holds, the execute stage waits
// and the two-entry queue fills; in_ready drops only once the queue is full.
module calibration_table_accumulator_unit (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [cta_pkg::LEN_W-1:0] cfg_wr_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      req_type,
    input  logic [7:0]                sample,
    input  logic                      end_of_frame,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [cta_pkg::IDX_W-1:0] entry_index,
    output logic [7:0]                entry_value,
    output logic                      written,
    output logic [cta_pkg::POS_W-1:0] table_length
);
    import cta_pkg::*;

    logic       q_push;
    logic       q_ready;
    cta_entry_t q_in_entry;
    logic       q_pop;
    logic       q_valid;
    cta_entry_t q_out_entry;

    // Front part: frame tracking and byte classification.
    cta_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .sample       (sample),
        .end_of_frame (end_of_frame),
        .q_ready      (q_ready),
        .q_push       (q_push),
        .q_entry      (q_in_entry)
    );

    // Decoupling queue.
    cta_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_in_entry),
        .push_ready (q_ready),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_entry  (q_out_entry)
    );

    // Back part: table read-modify-write and output register.
    cta_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_entry      (q_out_entry),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .entry_index  (entry_index),
        .entry_value  (entry_value),
        .written      (written),
        .table_length (table_length)
    );

endmodule
